// ===== src/otpt_pkg.sv =====
// Shared types and constants for the oscillating target position tracker.
package otpt_pkg;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 8;

    typedef enum logic [2:0] {
        ACT_COMMAND     = 3'd0,
        ACT_RECALIBRATE = 3'd1,
        ACT_TOGGLE      = 3'd2,
        ACT_LEFT_OPTO   = 3'd3,
        ACT_RIGHT_OPTO  = 3'd4,
        ACT_TICK_100MS  = 3'd5,
        ACT_TICK_1S     = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        DIR_LOST = 2'd0,
        DIR_LTR  = 2'd1,
        DIR_RTL  = 2'd2
    } t_dir;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MOTOR_DISABLED      = 4'd0,
        REG_CALIBRATION_SECONDS = 4'd1
    } t_reg_index;

    localparam logic [7:0] ST_TARGET_MASK = 8'h0F;
    localparam logic [7:0] ST_MOVING      = 8'h10;
    localparam logic [7:0] ST_TARGETING   = 8'h20;
    localparam logic [7:0] ST_CALIBRATING = 8'h40;
    localparam logic [7:0] DIST_MAX       = 8'd250;
    localparam logic [7:0] WIDTH_RESET    = 8'd7;
    localparam logic [7:0] CALIB_RESET    = 8'd5;
    localparam logic [1:0] EDGE_LEFT      = 2'b01;
    localparam logic [1:0] EDGE_RIGHT     = 2'b10;
    localparam logic [1:0] EDGE_BOTH      = 2'b11;

endpackage

// ===== src/otpt_if.sv =====
// Handshake channel interfaces for events, results and register writes.
interface otpt_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] command;
    logic       test_mode;

    modport source(output valid, action, command, test_mode, input ready);
    modport sink(input valid, action, command, test_mode, output ready);
endinterface

interface otpt_result_if;
    logic       valid;
    logic       ready;
    logic       motor_on;
    logic [7:0] status_now;
    logic [1:0] direction;
    logic [7:0] distance;
    logic [7:0] width;
    logic [1:0] error_flags;
    logic [7:0] seconds_left;

    modport source(output valid, motor_on, status_now, direction, distance, width,
                   error_flags, seconds_left, input ready);
    modport sink(input valid, motor_on, status_now, direction, distance, width,
                 error_flags, seconds_left, output ready);
endinterface

interface otpt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [otpt_pkg::CFG_INDEX_W-1:0] index;
    logic [otpt_pkg::CFG_DATA_W-1:0]  data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== src/oscillating_target_position_tracker_unit.sv =====
// Top level: target position tracker with event, result and register write channels.
//
//  Channel  Direction  Payload                                    Transfer
//  i_evt    in         action, command, test_mode                 valid && ready
//  o_res    out        motor_on, status_now, direction, distance,  valid && ready
//                      width, error_flags, seconds_left
//  i_cfg    in         index, data                                 valid && ready
//
// Events are handled combinationally; the result shows the cycle after its transfer.
// One event per cycle when not stalled; the result register is the only stage.
// The event channel stalls only while a result waits in the result register
// and the result channel is not ready. Register writes are always taken.
// Synchronous active-low reset clears all but result data; no clearing pass is needed.
module oscillating_target_position_tracker_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    otpt_event_if.sink            i_evt,
    otpt_result_if.source         o_res,
    otpt_cfg_if.sink              i_cfg
);

    logic       r_motor_disabled;
    logic [7:0] r_calib_seconds;

    logic [7:0] r_status, n_status;
    logic       r_motor, n_motor;
    logic [1:0] r_dir, n_dir;
    logic [7:0] r_dist, n_dist;
    logic [7:0] r_width, n_width;
    logic [1:0] r_edges, n_edges;
    logic [1:0] r_errors, n_errors;
    logic [7:0] r_timer, n_timer;

    logic       r_out_valid;
    logic       r_res_motor;
    logic [7:0] r_res_status;
    logic [1:0] r_res_dir;
    logic [7:0] r_res_dist;
    logic [7:0] r_res_width;
    logic [1:0] r_res_errors;
    logic [7:0] r_res_timer;

    logic       w_evt_xfer;
    logic       w_motor_allowed;
    logic [7:0] w_timer_dec;

    assign i_evt.ready     = !r_out_valid || o_res.ready;
    assign w_evt_xfer      = i_evt.valid && i_evt.ready;
    assign i_cfg.ready     = 1'b1;
    assign w_motor_allowed = !r_motor_disabled || i_evt.test_mode;
    assign w_timer_dec     = r_timer - 8'd1;

    always_comb begin
        n_status = r_status;
        n_motor  = r_motor;
        n_dir    = r_dir;
        n_dist   = r_dist;
        n_width  = r_width;
        n_edges  = r_edges;
        n_errors = r_errors;
        n_timer  = r_timer;
        case (otpt_pkg::t_action'(i_evt.action))
            otpt_pkg::ACT_COMMAND: begin
                n_status = i_evt.command;
                n_motor  = |(i_evt.command & otpt_pkg::ST_MOVING) && w_motor_allowed;
            end
            otpt_pkg::ACT_RECALIBRATE: begin
                n_width  = otpt_pkg::WIDTH_RESET;
                n_edges  = 2'b00;
                n_errors = 2'b00;
                n_dir    = otpt_pkg::DIR_LOST;
                n_timer  = r_calib_seconds;
                n_status = otpt_pkg::ST_MOVING | otpt_pkg::ST_CALIBRATING;
                n_motor  = w_motor_allowed;
            end
            otpt_pkg::ACT_TOGGLE: begin
                if (!(|(r_status & otpt_pkg::ST_CALIBRATING))) begin
                    if (|(r_status & otpt_pkg::ST_MOVING)) begin
                        n_status = 8'h00;
                        n_motor  = 1'b0;
                    end else begin
                        n_status = otpt_pkg::ST_MOVING;
                        n_motor  = w_motor_allowed;
                    end
                end
            end
            otpt_pkg::ACT_LEFT_OPTO: begin
                n_edges  = r_edges | otpt_pkg::EDGE_LEFT;
                n_errors = r_errors & ~otpt_pkg::EDGE_LEFT;
                n_dir    = otpt_pkg::DIR_LTR;
                n_dist   = 8'd0;
            end
            otpt_pkg::ACT_RIGHT_OPTO: begin
                n_edges  = r_edges | otpt_pkg::EDGE_RIGHT;
                n_errors = r_errors & ~otpt_pkg::EDGE_RIGHT;
                if (r_dir != otpt_pkg::DIR_RTL && r_dist > r_width) begin
                    n_width = r_dist;
                end
                n_dir = otpt_pkg::DIR_RTL;
            end
            otpt_pkg::ACT_TICK_100MS: begin
                if (|(r_status & otpt_pkg::ST_MOVING)) begin
                    if (r_dir[0]) begin
                        if (r_dist < otpt_pkg::DIST_MAX) begin
                            n_dist = r_dist + 8'd1;
                        end
                    end else if (r_dist != 8'd0) begin
                        n_dist = r_dist - 8'd1;
                    end
                    if (|(r_status & otpt_pkg::ST_TARGETING)) begin
                        if ((r_status & otpt_pkg::ST_TARGET_MASK) == n_dist) begin
                            n_status = 8'h00;
                            n_motor  = 1'b0;
                        end
                    end else if (|(r_status & otpt_pkg::ST_CALIBRATING)) begin
                        if (r_edges == otpt_pkg::EDGE_BOTH) begin
                            n_status = 8'h00;
                            n_motor  = 1'b0;
                        end
                    end
                end
            end
            otpt_pkg::ACT_TICK_1S: begin
                if (|(r_status & otpt_pkg::ST_CALIBRATING)) begin
                    if (r_edges == otpt_pkg::EDGE_BOTH) begin
                        n_status = 8'h00;
                        n_motor  = 1'b0;
                    end else begin
                        n_timer = w_timer_dec;
                        if (w_timer_dec == 8'd0) begin
                            n_errors = r_errors | ~r_edges;
                            n_status = 8'h00;
                            n_motor  = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_disabled <= 1'b0;
            r_calib_seconds  <= otpt_pkg::CALIB_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                otpt_pkg::REG_MOTOR_DISABLED:      r_motor_disabled <= i_cfg.data[0];
                otpt_pkg::REG_CALIBRATION_SECONDS: r_calib_seconds  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= 8'h00;
            r_motor  <= 1'b0;
            r_dir    <= otpt_pkg::DIR_LOST;
            r_dist   <= 8'd0;
            r_width  <= otpt_pkg::WIDTH_RESET;
            r_edges  <= 2'b00;
            r_errors <= 2'b00;
            r_timer  <= 8'd0;
        end else if (w_evt_xfer) begin
            r_status <= n_status;
            r_motor  <= n_motor;
            r_dir    <= n_dir;
            r_dist   <= n_dist;
            r_width  <= n_width;
            r_edges  <= n_edges;
            r_errors <= n_errors;
            r_timer  <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_evt_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt_xfer) begin
            r_res_motor  <= n_motor;
            r_res_status <= n_status;
            r_res_dir    <= n_dir;
            r_res_dist   <= n_dist;
            r_res_width  <= n_width;
            r_res_errors <= n_errors;
            r_res_timer  <= n_timer;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.motor_on     = r_res_motor;
    assign o_res.status_now   = r_res_status;
    assign o_res.direction    = r_res_dir;
    assign o_res.distance     = r_res_dist;
    assign o_res.width        = r_res_width;
    assign o_res.error_flags  = r_res_errors;
    assign o_res.seconds_left = r_res_timer;

    a_dist_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= otpt_pkg::DIST_MAX)
        else $error("Distance count exceeded its saturation limit.");

    a_error_only_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_errors & r_edges) == 2'b00)
        else $error("An edge is flagged missing although it was seen.");

    a_motor_needs_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_motor |-> |(r_status & otpt_pkg::ST_MOVING))
        else $error("Motor is enabled while the status is not moving.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_evt_xfer |=> r_out_valid && r_res_dist == r_dist && r_res_status == r_status)
        else $error("Result register does not match the state after a transfer.");

endmodule
